[sv/avimd_pkg.sv]
// shared types, constants and helpers of the avi movi stream demux
package avimd_pkg;

   localparam int QueueDepth = 4;

   localparam logic [31:0] FccRiff = 32'h4646_4952;
   localparam logic [31:0] FccList = 32'h5453_494C;
   localparam logic [31:0] FccMovi = 32'h6976_6F6D;
   localparam logic [31:0] FccRec  = 32'h2063_6572;
   localparam logic [31:0] FccJunk = 32'h4B4E_554A;
   localparam logic [31:0] FccIdx1 = 32'h3178_6469;
   localparam logic [15:0] TwoDb   = 16'h6264;
   localparam logic [15:0] TwoDc   = 16'h6364;
   localparam logic [15:0] TwoWb   = 16'h6277;
   localparam logic [15:0] TwoIx   = 16'h7869;
   localparam logic [31:0] HeaderEnd = 32'd12;

   typedef enum logic [2:0] {
      PH_HDR, PH_FORM, PH_S_ID, PH_S_SIZE, PH_S_TYPE, PH_M_ID, PH_M_SIZE, PH_M_TYPE
   } phase_type;

   typedef enum logic [1:0] {
      RT_SKIP, RT_VIDEO, RT_AUDIO, RT_LIST
   } route_type;

   typedef enum logic [1:0] {
      KIND_VIDEO = 2'd0,
      KIND_AUDIO = 2'd1,
      KIND_EVENT = 2'd2
   } kind_type;

   typedef enum logic [2:0] {
      EV_IDX1_END     = 3'd0,
      EV_FILE_END     = 3'd1,
      EV_NOT_RIFF     = 3'd2,
      EV_SIZE_BAD     = 3'd3,
      EV_NO_MOVI      = 3'd4,
      EV_UNKNOWN      = 3'd5,
      EV_NONE_ENABLED = 3'd6
   } event_type;

   typedef enum logic [2:0] {
      CSR_FILE_SIZE      = 3'd0,
      CSR_VIDEO_ENABLE   = 3'd1,
      CSR_AUDIO_ENABLE   = 3'd2,
      CSR_HEADER_POLICY  = 3'd3,
      CSR_UNKNOWN_POLICY = 3'd4
   } csr_index_type;

   localparam logic [1:0] UnkHalt  = 2'd0;
   localparam logic [1:0] UnkFirst = 2'd2;

   typedef struct packed {
      logic [1:0] kind;
      logic [7:0] payload;
      logic [2:0] event_code;
      logic       halted;
      logic       last_of_run;
   } result_type;

   // one accepted byte worth of results: r0 always, r1 when two is set
   typedef struct packed {
      logic       two;
      result_type r0;
      result_type r1;
   } entry_type;

   typedef struct packed {
      logic full;
      logic empty;
   } queue_status_type;

   function automatic result_type mk_res(logic [1:0] kind, logic [7:0] pay,
                                         logic [2:0] ev, logic halt);
      result_type r;
      r.kind        = kind;
      r.payload     = pay;
      r.event_code  = ev;
      r.halted      = halt;
      r.last_of_run = 1'b0;
      return r;
   endfunction

   function automatic logic [7:0] tag_byte(logic [1:0] k);
      logic [7:0] t;
      unique case (k)
         2'd0: t = 8'h4D;
         2'd1: t = 8'h50;
         2'd2: t = 8'h34;
         default: t = 8'h55;
      endcase
      return t;
   endfunction

endpackage

[sv/avi_movi_stream_demux.sv]
// top level of the avi movi stream demux
//
// file bytes enter on the req_ queue port: a beat is taken when req_push is
// high and req_full is low, one beat per cycle. results leave on the rsp_
// queue port: the oldest result sits on the rsp_ fields while rsp_empty is
// low and goes when rsp_pop is high. each result is a video byte, an audio
// byte or an event; rsp_last_of_run marks the final result of one file byte,
// and a byte may give none, one or two results.
// path: a byte's results are written to the queue at the edge that takes the
// byte and then pass one by one through the output register.
// throughput: one file byte per cycle while req_full is low; one result per
// cycle, set by the single output register, while the receiver keeps popping.
// the parser and the output register are parted by a queue of Depth groups,
// so bytes keep flowing while a result waits; req_full is high exactly while
// that queue is full. registers are written on the csr_ port, always ready;
// the user is to write them between files; the block does not enforce it.
// reset clears the parser to the header check, empties the queue and loads
// the register defaults; after a halting event further bytes give nothing.
module avi_movi_stream_demux #(
   parameter int Depth = avimd_pkg::QueueDepth
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_push,
   output logic        req_full,
   input  logic [7:0]  req_file_byte,
   output logic        rsp_empty,
   input  logic        rsp_pop,
   output logic [1:0]  rsp_kind,
   output logic [7:0]  rsp_payload,
   output logic [2:0]  rsp_event_code,
   output logic        rsp_halted,
   output logic        rsp_last_of_run,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [2:0]  csr_index,
   input  logic [31:0] csr_data
);

   avimd_pkg::queue_status_type q_status;
   avimd_pkg::entry_type        q_entry, q_head;
   avimd_pkg::result_type       out_res;
   logic                        q_push, q_pop;

   assign csr_ready = 1'b1;
   assign req_full  = q_status.full;

   avimd_parse u_parse (
      .clock         (clock),
      .reset         (reset),
      .req_push      (req_push),
      .req_file_byte (req_file_byte),
      .csr_valid     (csr_valid),
      .csr_index     (csr_index),
      .csr_data      (csr_data),
      .q_status      (q_status),
      .q_push        (q_push),
      .q_entry       (q_entry)
   );

   avimd_queue #(.Depth(Depth)) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (q_push),
      .push_entry (q_entry),
      .pop        (q_pop),
      .head       (q_head),
      .status     (q_status)
   );

   avimd_emit u_emit (
      .clock     (clock),
      .reset     (reset),
      .head      (q_head),
      .q_status  (q_status),
      .q_pop     (q_pop),
      .rsp_pop   (rsp_pop),
      .rsp_empty (rsp_empty),
      .out_res   (out_res)
   );

   assign rsp_kind        = out_res.kind;
   assign rsp_payload     = out_res.payload;
   assign rsp_event_code  = out_res.event_code;
   assign rsp_halted      = out_res.halted;
   assign rsp_last_of_run = out_res.last_of_run;

endmodule

[sv/avimd_parse.sv]
// front end: register file, chunk parser and result builder; one byte per cycle unless the queue is full
module avimd_parse (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_push,
   input  logic [7:0]                req_file_byte,
   input  logic                      csr_valid,
   input  logic [2:0]                csr_index,
   input  logic [31:0]               csr_data,
   input  avimd_pkg::queue_status_type q_status,
   output logic                      q_push,
   output avimd_pkg::entry_type      q_entry
);

   logic [31:0] file_size_ff;
   logic        video_enable_ff, audio_enable_ff, header_policy_ff;
   logic [1:0]  unknown_policy_ff;

   avimd_pkg::phase_type phase_ff, phase_in;
   avimd_pkg::route_type route_ff, route_in;
   logic [31:0] pos_ff, pos_in;
   logic [31:0] shift_ff, shift_in;
   logic [1:0]  fbc_ff, fbc_in;
   logic [31:0] rem_ff, rem_in;
   logic        pad_ff, pad_in;
   logic        unk_rep_ff, unk_rep_in;
   logic        done_ff, done_in;

   logic                  accept;
   logic [31:0]           shift_c;
   logic                  take_done;
   logic                  in_movi;
   logic                  stop;
   logic [1:0]            n_c;
   avimd_pkg::result_type res_c [2];
   logic [15:0]           hi_c, lo_c;
   logic [31:0]           want_c;

   assign accept = req_push && !q_status.full;

   always_ff @(posedge clock) begin
      if (reset) begin
         file_size_ff      <= '0;
         video_enable_ff   <= 1'b1;
         audio_enable_ff   <= 1'b1;
         header_policy_ff  <= 1'b1;
         unknown_policy_ff <= 2'd1;
      end else if (csr_valid) begin
         unique case (csr_index)
            avimd_pkg::CSR_FILE_SIZE:      file_size_ff      <= csr_data;
            avimd_pkg::CSR_VIDEO_ENABLE:   video_enable_ff   <= csr_data[0];
            avimd_pkg::CSR_AUDIO_ENABLE:   audio_enable_ff   <= csr_data[0];
            avimd_pkg::CSR_HEADER_POLICY:  header_policy_ff  <= csr_data[0];
            avimd_pkg::CSR_UNKNOWN_POLICY: unknown_policy_ff <= csr_data[1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      shift_c   = {req_file_byte, shift_ff[31:8]};
      take_done = (fbc_ff == 2'd3);
      in_movi   = (phase_ff == avimd_pkg::PH_M_ID) || (phase_ff == avimd_pkg::PH_M_SIZE) ||
                  (phase_ff == avimd_pkg::PH_M_TYPE);
      hi_c      = shift_c[31:16];
      lo_c      = shift_c[15:0];
      want_c    = (phase_ff == avimd_pkg::PH_S_TYPE) ? avimd_pkg::FccMovi : avimd_pkg::FccRec;
      phase_in   = phase_ff;
      route_in   = route_ff;
      pos_in     = pos_ff;
      shift_in   = shift_ff;
      fbc_in     = fbc_ff;
      rem_in     = rem_ff;
      pad_in     = pad_ff;
      unk_rep_in = unk_rep_ff;
      done_in    = done_ff;
      stop       = 1'b0;
      n_c        = 2'd0;
      res_c[0]   = '0;
      res_c[1]   = '0;

      if (!done_ff) begin
         unique case (phase_ff)
            avimd_pkg::PH_HDR: begin
               shift_in = shift_c;
               fbc_in   = take_done ? 2'd0 : fbc_ff + 2'd1;
               if (take_done) begin
                  if (pos_ff == 32'd3) begin
                     if (shift_c != avimd_pkg::FccRiff) begin
                        stop = !header_policy_ff;
                        res_c[n_c[0]] = avimd_pkg::mk_res(avimd_pkg::KIND_EVENT, 8'd0,
                                                          avimd_pkg::EV_NOT_RIFF, stop);
                        n_c = n_c + 2'd1;
                     end
                  end else begin
                     if (shift_c != file_size_ff - 32'd8) begin
                        stop = !header_policy_ff;
                        res_c[n_c[0]] = avimd_pkg::mk_res(avimd_pkg::KIND_EVENT, 8'd0,
                                                          avimd_pkg::EV_SIZE_BAD, stop);
                        n_c = n_c + 2'd1;
                     end
                     if (!stop && !video_enable_ff && !audio_enable_ff) begin
                        stop = 1'b1;
                        res_c[n_c[0]] = avimd_pkg::mk_res(avimd_pkg::KIND_EVENT, 8'd0,
                                                          avimd_pkg::EV_NONE_ENABLED, 1'b1);
                        n_c = n_c + 2'd1;
                     end
                     if (!stop) begin
                        phase_in = avimd_pkg::PH_FORM;
                        fbc_in   = 2'd0;
                     end
                  end
               end
            end
            avimd_pkg::PH_FORM: begin
               if (video_enable_ff) begin
                  res_c[n_c[0]] = avimd_pkg::mk_res(avimd_pkg::KIND_VIDEO,
                                                    avimd_pkg::tag_byte(pos_ff[1:0]),
                                                    3'd0, 1'b0);
                  n_c = n_c + 2'd1;
               end
               if (pos_ff[1:0] == 2'd3) begin
                  phase_in = avimd_pkg::PH_S_ID;
                  fbc_in   = 2'd0;
               end
            end
            avimd_pkg::PH_S_ID, avimd_pkg::PH_M_ID: begin
               if (rem_ff != 32'd0) begin
                  if (in_movi && route_ff == avimd_pkg::RT_VIDEO && video_enable_ff) begin
                     res_c[n_c[0]] = avimd_pkg::mk_res(avimd_pkg::KIND_VIDEO, req_file_byte,
                                                       3'd0, 1'b0);
                     n_c = n_c + 2'd1;
                  end else if (in_movi && route_ff == avimd_pkg::RT_AUDIO && audio_enable_ff) begin
                     res_c[n_c[0]] = avimd_pkg::mk_res(avimd_pkg::KIND_AUDIO, req_file_byte,
                                                       3'd0, 1'b0);
                     n_c = n_c + 2'd1;
                  end
                  rem_in = rem_ff - 32'd1;
               end else if (pad_ff) begin
                  pad_in = 1'b0;
               end else begin
                  shift_in = shift_c;
                  fbc_in   = take_done ? 2'd0 : fbc_ff + 2'd1;
                  if (take_done) begin
                     if (!in_movi) begin
                        route_in = (shift_c == avimd_pkg::FccList) ? avimd_pkg::RT_LIST
                                                                   : avimd_pkg::RT_SKIP;
                        phase_in = avimd_pkg::PH_S_SIZE;
                     end else if (shift_c == avimd_pkg::FccList) begin
                        route_in = avimd_pkg::RT_LIST;
                        phase_in = avimd_pkg::PH_M_SIZE;
                     end else if (hi_c == avimd_pkg::TwoDb || hi_c == avimd_pkg::TwoDc) begin
                        route_in = avimd_pkg::RT_VIDEO;
                        phase_in = avimd_pkg::PH_M_SIZE;
                     end else if (hi_c == avimd_pkg::TwoWb) begin
                        route_in = avimd_pkg::RT_AUDIO;
                        phase_in = avimd_pkg::PH_M_SIZE;
                     end else if (hi_c == avimd_pkg::TwoIx || lo_c == avimd_pkg::TwoIx ||
                                  shift_c == avimd_pkg::FccJunk) begin
                        route_in = avimd_pkg::RT_SKIP;
                        phase_in = avimd_pkg::PH_M_SIZE;
                     end else if (shift_c == avimd_pkg::FccIdx1) begin
                        stop = 1'b1;
                        res_c[n_c[0]] = avimd_pkg::mk_res(avimd_pkg::KIND_EVENT, 8'd0,
                                                          avimd_pkg::EV_IDX1_END, 1'b1);
                        n_c = n_c + 2'd1;
                     end else if (unknown_policy_ff == avimd_pkg::UnkHalt) begin
                        stop = 1'b1;
                        res_c[n_c[0]] = avimd_pkg::mk_res(avimd_pkg::KIND_EVENT, 8'd0,
                                                          avimd_pkg::EV_UNKNOWN, 1'b1);
                        n_c = n_c + 2'd1;
                     end else if (unknown_policy_ff != avimd_pkg::UnkFirst || !unk_rep_ff) begin
                        unk_rep_in = 1'b1;
                        res_c[n_c[0]] = avimd_pkg::mk_res(avimd_pkg::KIND_EVENT, 8'd0,
                                                          avimd_pkg::EV_UNKNOWN, 1'b0);
                        n_c = n_c + 2'd1;
                     end
                  end
               end
            end
            avimd_pkg::PH_S_SIZE, avimd_pkg::PH_M_SIZE: begin
               if (in_movi && route_ff == avimd_pkg::RT_VIDEO && video_enable_ff) begin
                  res_c[n_c[0]] = avimd_pkg::mk_res(avimd_pkg::KIND_VIDEO, req_file_byte,
                                                    3'd0, 1'b0);
                  n_c = n_c + 2'd1;
               end
               shift_in = shift_c;
               fbc_in   = take_done ? 2'd0 : fbc_ff + 2'd1;
               if (take_done) begin
                  rem_in = shift_c;
                  if (route_ff == avimd_pkg::RT_LIST) begin
                     phase_in = in_movi ? avimd_pkg::PH_M_TYPE : avimd_pkg::PH_S_TYPE;
                  end else begin
                     pad_in   = shift_c[0];
                     phase_in = in_movi ? avimd_pkg::PH_M_ID : avimd_pkg::PH_S_ID;
                  end
               end
            end
            default: begin
               // list type word; rem holds the list size
               shift_in = shift_c;
               fbc_in   = take_done ? 2'd0 : fbc_ff + 2'd1;
               if (take_done) begin
                  route_in = avimd_pkg::RT_SKIP;
                  if (shift_c == want_c) begin
                     rem_in = 32'd0;
                     pad_in = 1'b0;
                  end else begin
                     rem_in = (rem_ff >= 32'd4) ? rem_ff - 32'd4 : 32'd0;
                     pad_in = rem_ff[0];
                  end
                  phase_in = (phase_ff == avimd_pkg::PH_S_TYPE &&
                              shift_c != avimd_pkg::FccMovi) ? avimd_pkg::PH_S_ID
                                                             : avimd_pkg::PH_M_ID;
               end
            end
         endcase

         if (!stop) begin
            pos_in = pos_ff + 32'd1;
            if (pos_in >= avimd_pkg::HeaderEnd && pos_in >= file_size_ff) begin
               stop = 1'b1;
               res_c[n_c[0]] = avimd_pkg::mk_res(avimd_pkg::KIND_EVENT, 8'd0,
                                                 in_movi ? avimd_pkg::EV_FILE_END
                                                         : avimd_pkg::EV_NO_MOVI, 1'b1);
               n_c = n_c + 2'd1;
            end
         end
         if (stop) begin
            done_in = 1'b1;
         end
      end

      if (n_c == 2'd1) begin
         res_c[0].last_of_run = 1'b1;
      end else begin
         res_c[1].last_of_run = 1'b1;
      end
      q_entry.two = n_c[1];
      q_entry.r0  = res_c[0];
      q_entry.r1  = res_c[1];
      q_push      = accept && (n_c != 2'd0);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff   <= avimd_pkg::PH_HDR;
         route_ff   <= avimd_pkg::RT_SKIP;
         pos_ff     <= '0;
         shift_ff   <= '0;
         fbc_ff     <= '0;
         rem_ff     <= '0;
         pad_ff     <= 1'b0;
         unk_rep_ff <= 1'b0;
         done_ff    <= 1'b0;
      end else if (accept) begin
         phase_ff   <= phase_in;
         route_ff   <= route_in;
         pos_ff     <= pos_in;
         shift_ff   <= shift_in;
         fbc_ff     <= fbc_in;
         rem_ff     <= rem_in;
         pad_ff     <= pad_in;
         unk_rep_ff <= unk_rep_in;
         done_ff    <= done_in;
      end
   end

endmodule

[sv/avimd_queue.sv]
// small queue of per-byte result groups between parser and emitter
module avimd_queue #(
   parameter int Depth = avimd_pkg::QueueDepth
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        push,
   input  avimd_pkg::entry_type        push_entry,
   input  logic                        pop,
   output avimd_pkg::entry_type        head,
   output avimd_pkg::queue_status_type status
);

   localparam int AW = (Depth > 1) ? $clog2(Depth) : 1;
   localparam int CW = $clog2(Depth + 1);

   avimd_pkg::entry_type mem_ff [Depth];
   logic [AW-1:0] wr_ff, wr_in, rd_ff, rd_in;
   logic [CW-1:0] cnt_ff, cnt_in;
   logic          do_push, do_pop;

   assign status.full  = (cnt_ff == CW'(Depth));
   assign status.empty = (cnt_ff == '0);
   assign do_push      = push && !status.full;
   assign do_pop       = pop && !status.empty;
   assign head         = mem_ff[rd_ff];

   always_comb begin
      wr_in  = do_push ? ((wr_ff == AW'(Depth - 1)) ? '0 : wr_ff + AW'(1)) : wr_ff;
      rd_in  = do_pop  ? ((rd_ff == AW'(Depth - 1)) ? '0 : rd_ff + AW'(1)) : rd_ff;
      cnt_in = cnt_ff + CW'(do_push) - CW'(do_pop);
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ff] <= push_entry;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff  <= '0;
         rd_ff  <= '0;
         cnt_ff <= '0;
      end else begin
         wr_ff  <= wr_in;
         rd_ff  <= rd_in;
         cnt_ff <= cnt_in;
      end
   end

endmodule

[sv/avimd_emit.sv]
// back end: splits result groups into single beats held in the output register
module avimd_emit (
   input  logic                        clock,
   input  logic                        reset,
   input  avimd_pkg::entry_type        head,
   input  avimd_pkg::queue_status_type q_status,
   output logic                        q_pop,
   input  logic                        rsp_pop,
   output logic                        rsp_empty,
   output avimd_pkg::result_type       out_res
);

   logic                  valid_ff, valid_in;
   logic                  sub_ff, sub_in;
   avimd_pkg::result_type res_ff, res_in;
   logic                  load, take;

   assign load      = !valid_ff || rsp_pop;
   assign take      = load && !q_status.empty;
   assign rsp_empty = !valid_ff;
   assign out_res   = res_ff;

   always_comb begin
      valid_in = valid_ff;
      sub_in   = sub_ff;
      res_in   = res_ff;
      q_pop    = 1'b0;
      if (load) begin
         valid_in = !q_status.empty;
      end
      if (take) begin
         if (sub_ff) begin
            res_in = head.r1;
            sub_in = 1'b0;
            q_pop  = 1'b1;
         end else begin
            res_in = head.r0;
            if (head.two) begin
               sub_in = 1'b1;
            end else begin
               q_pop = 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      res_ff <= res_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
         sub_ff   <= 1'b0;
      end else begin
         valid_ff <= valid_in;
         sub_ff   <= sub_in;
      end
   end

endmodule
